### hdl/btffa_pkg.sv
// ----------------------------------------------------------------------------
// btffa_pkg
// Shared constants and codes for the boundary-tag first-fit heap allocator.
// ----------------------------------------------------------------------------
package btffa_pkg;

  // Heap geometry in bytes
  localparam int unsigned STORE_BYTES = 65536;
  localparam int unsigned HEAD_BYTES = 32;
  localparam int unsigned FOOT_BYTES = 8;
  localparam int unsigned OVERHEAD   = HEAD_BYTES + FOOT_BYTES;
  localparam int unsigned HEAP_MIN   = (OVERHEAD > 48) ? OVERHEAD : 48;

  // Widths
  localparam int unsigned ADDR_W = 16;  // byte offset into the tag store
  localparam int unsigned LINK_W = 17;  // offset or null link
  localparam int unsigned SIZE_W = 16;  // block payload size
  localparam int unsigned CNT_W  = 11;  // block counters
  localparam int unsigned HSZ_W  = 17;  // heap size register

  // Null link of the available list
  localparam logic [LINK_W-1:0] NIL = LINK_W'(STORE_BYTES);

  // Header state tags
  typedef enum logic [1:0] {
    BLK_NONE  = 2'd0,
    BLK_AVAIL = 2'd1,
    BLK_USED  = 2'd2
  } blk_state_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  // Operation codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Register index decoded from paddr[2]
  localparam logic REG_HEAP_SIZE = 1'b0;

endpackage

### hdl/boundary_tag_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_top
// Explicit free-list first-fit heap allocator with boundary tags and merging.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_axis channel: tuser carries the operation
//   (0 allocate, 1 free), tdata carries request_size and free_offset. Each
//   request yields exactly one response on the m_axis channel with status in
//   tuser and payload_offset, avail_count and used_count in tdata.
//   Requests are handled one at a time. The list walk, one tag-memory read
//   per node, sets the allocate time; the single read port shared by the
//   header memories sets the read-modify-write steps of a free.
//   The response sits in an output register; a new request is accepted while
//   it waits. A stalled receiver holds the block only when a second response
//   is ready before the first was taken.
//   After reset, and after each write of heap_size over the APB port, a
//   clearing pass resets every header tag; no request is accepted meanwhile.
//   heap_size is saturated to 48..65536.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [16:0] request_size, [32:17] free_offset
  input  logic        s_axis_tuser,   // [0] operation
  // response channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] payload_offset, [26:16] avail_count,
                                      // [37:27] used_count
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [18:0] {
    S_CLR   = 19'b000_0000_0000_0000_0001,
    S_IDLE  = 19'b000_0000_0000_0000_0010,
    S_A_CHK = 19'b000_0000_0000_0000_0100,
    S_A_EV  = 19'b000_0000_0000_0000_1000,
    S_A_RM  = 19'b000_0000_0000_0001_0000,
    S_A_SP1 = 19'b000_0000_0000_0010_0000,
    S_A_SP2 = 19'b000_0000_0000_0100_0000,
    S_F_CHK = 19'b000_0000_0000_1000_0000,
    S_F_EV  = 19'b000_0000_0001_0000_0000,
    S_F_P2  = 19'b000_0000_0010_0000_0000,
    S_M_RD  = 19'b000_0000_0100_0000_0000,
    S_M_EV1 = 19'b000_0000_1000_0000_0000,
    S_M_EV2 = 19'b000_0001_0000_0000_0000,
    S_M_RU  = 19'b000_0010_0000_0000_0000,
    S_M_P1  = 19'b000_0100_0000_0000_0000,
    S_M_P2  = 19'b000_1000_0000_0000_0000,
    S_M_END = 19'b001_0000_0000_0000_0000,
    S_B_EV  = 19'b010_0000_0000_0000_0000,
    S_RESP  = 19'b100_0000_0000_0000_0000
  } fsm_e;

  localparam int unsigned AW = btffa_pkg::ADDR_W;
  localparam int unsigned LW = btffa_pkg::LINK_W;
  localparam int unsigned SW = btffa_pkg::SIZE_W;
  localparam int unsigned CW = btffa_pkg::CNT_W;
  localparam int unsigned HW = btffa_pkg::HSZ_W;
  localparam int unsigned DEPTH = btffa_pkg::STORE_BYTES;
  localparam logic [LW-1:0] NIL = btffa_pkg::NIL;
  localparam logic [17:0] OVH18 = 18'(btffa_pkg::OVERHEAD);
  localparam logic [HW-1:0] OVH17 = HW'(btffa_pkg::OVERHEAD);
  localparam logic [HW-1:0] HEAD17 = HW'(btffa_pkg::HEAD_BYTES);
  localparam logic [AW-1:0] HEAD16 = AW'(btffa_pkg::HEAD_BYTES);
  localparam logic [AW-1:0] FOOT16 = AW'(btffa_pkg::FOOT_BYTES);
  localparam logic [SW-1:0] OVH16 = SW'(btffa_pkg::OVERHEAD);
  localparam logic [HW-1:0] HMIN = HW'(btffa_pkg::HEAP_MIN);
  localparam logic [HW-1:0] HMAX = HW'(btffa_pkg::STORE_BYTES);

  // Tag memories
  logic [SW-1:0] size_mem  [DEPTH];
  logic [1:0]    state_mem [DEPTH];
  logic [LW-1:0] next_mem  [DEPTH];
  logic [LW-1:0] prev_mem  [DEPTH];
  logic [SW-1:0] foot_mem  [DEPTH];

  logic [SW-1:0] size_rd_q, foot_rd_q;
  logic [1:0]    state_rd_q;
  logic [LW-1:0] next_rd_q, prev_rd_q;

  logic [AW-1:0] hdr_ra, foot_ra;
  logic          size_we, state_we, next_we, prev_we, foot_we;
  logic [AW-1:0] size_wa, state_wa, next_wa, prev_wa, foot_wa;
  logic [SW-1:0] size_wd, foot_wd;
  logic [1:0]    state_wd;
  logic [LW-1:0] next_wd, prev_wd;

  // Control and working registers
  fsm_e          state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [HW-1:0] hs_q, hs_d;
  logic [LW-1:0] first_q, first_d;
  logic [CW-1:0] avail_q, avail_d, used_q, used_d;
  logic [HW-1:0] req_q, req_d;
  logic [AW-1:0] fo_q, fo_d;
  logic [LW-1:0] f_q, f_d;
  logic [CW-1:0] k_q, k_d;
  logic [SW-1:0] olds_q, olds_d;
  logic [LW-1:0] p_q, p_d, n_q, n_d;
  logic [AW-1:0] b_q, b_d;
  logic [LW-1:0] lo_q, lo_d;
  logic [AW-1:0] up_q, up_d;
  logic [SW-1:0] szlo_q, szlo_d, szup_q, szup_d;
  logic [LW-1:0] plo_q, plo_d, nlo_q, nlo_d, pup_q, pup_d, nup_q, nup_d;
  logic          phase_q, phase_d;
  btffa_pkg::status_e status_q, status_d;
  logic [AW-1:0] pay_q, pay_d;
  logic          out_valid_q, out_valid_d;
  logic [39:0]   out_data_q, out_data_d;
  logic [1:0]    out_user_q, out_user_d;

  // Derived values
  logic          cfg_we, in_fire, split_w;
  logic [HW-1:0] cfg_val, hs_sat;
  logic [SW-1:0] left_w, ns_w;
  logic [AW-1:0] nb_w, b_w, bb_f;
  logic [17:0]   up_w;
  logic [HW-1:0] bb_lim;
  logic [LW-1:0] pup_w, nup_w;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == btffa_pkg::REG_HEAP_SIZE);
  assign prdata = (paddr[2] == btffa_pkg::REG_HEAP_SIZE) ? {15'd0, hs_q} : 32'd0;

  // heap_size saturation
  assign cfg_val = pwdata[HW-1:0];
  assign hs_sat  = (cfg_val < HMIN) ? HMIN : ((cfg_val > HMAX) ? HMAX : cfg_val);

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Split arithmetic
  assign split_w = {2'b0, olds_q} >= ({1'b0, req_q} + OVH18);
  assign left_w  = SW'({1'b0, olds_q} - req_q - OVH17);
  assign nb_w    = AW'(f_q + req_q + OVH17);
  // Merge arithmetic
  assign up_w    = {1'b0, lo_q} + {2'b0, size_rd_q} + OVH18;
  assign ns_w    = szlo_q + OVH16 + szup_q;
  assign pup_w   = (nlo_q == {1'b0, up_q}) ? plo_q : prev_rd_q;
  assign nup_w   = (plo_q == {1'b0, up_q}) ? nlo_q : next_rd_q;
  // Neighbor below via its footer
  assign b_w     = fo_q - HEAD16;
  assign bb_f    = b_q - FOOT16;
  assign bb_lim  = HEAD17 + {1'b0, foot_rd_q};

  // Sequencer
  always_comb begin
    state_d = state_q;   clr_d = clr_q;     hs_d = hs_q;
    first_d = first_q;   avail_d = avail_q; used_d = used_q;
    req_d = req_q;       fo_d = fo_q;       f_d = f_q;   k_d = k_q;
    olds_d = olds_q;     p_d = p_q;         n_d = n_q;   b_d = b_q;
    lo_d = lo_q;         up_d = up_q;       szlo_d = szlo_q; szup_d = szup_q;
    plo_d = plo_q;       nlo_d = nlo_q;     pup_d = pup_q;   nup_d = nup_q;
    phase_d = phase_q;   status_d = status_q; pay_d = pay_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d = out_data_q; out_user_d = out_user_q;

    hdr_ra = f_q[AW-1:0]; foot_ra = bb_f;
    size_we = 1'b0;  size_wa = '0;  size_wd = '0;
    state_we = 1'b0; state_wa = '0; state_wd = '0;
    next_we = 1'b0;  next_wa = '0;  next_wd = '0;
    prev_we = 1'b0;  prev_wa = '0;  prev_wd = '0;
    foot_we = 1'b0;  foot_wa = '0;  foot_wd = '0;

    unique case (state_q)
      // clearing sweep over all header tags, seeding one block at offset 0
      S_CLR: begin
        state_we = 1'b1;
        state_wa = clr_q;
        state_wd = (clr_q == '0) ? btffa_pkg::BLK_AVAIL : btffa_pkg::BLK_NONE;
        if (clr_q == '0) begin
          size_we = 1'b1; size_wa = '0; size_wd = SW'(hs_q - OVH17);
          next_we = 1'b1; next_wa = '0; next_wd = NIL;
          prev_we = 1'b1; prev_wa = '0; prev_wd = NIL;
          foot_we = 1'b1; foot_wa = AW'(hs_q - HW'(btffa_pkg::FOOT_BYTES));
          foot_wd = SW'(hs_q - OVH17);
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          req_d = s_axis_tdata[16:0];
          fo_d  = s_axis_tdata[32:17];
          f_d   = first_q;
          k_d   = '0;
          pay_d = '0;
          status_d = btffa_pkg::ST_OK;
          state_d = (s_axis_tuser == btffa_pkg::OP_FREE) ? S_F_CHK : S_A_CHK;
        end
      end
      // first-fit walk
      S_A_CHK: begin
        hdr_ra = f_q[AW-1:0];
        if (f_q[LW-1] || k_q >= avail_q) begin
          status_d = btffa_pkg::ST_NOFIT;
          state_d  = S_RESP;
        end else begin
          state_d = S_A_EV;
        end
      end
      S_A_EV: begin
        if (state_rd_q == btffa_pkg::BLK_AVAIL && {1'b0, size_rd_q} >= req_q) begin
          olds_d = size_rd_q;
          p_d = prev_rd_q;
          n_d = next_rd_q;
          state_d = S_A_RM;
        end else begin
          f_d = next_rd_q;
          k_d = k_q + 1'b1;
          state_d = S_A_CHK;
        end
      end
      // unlink the fit, mark used, trim when splitting
      S_A_RM: begin
        if (p_q[LW-1]) begin
          first_d = n_q;
        end else begin
          next_we = 1'b1; next_wa = p_q[AW-1:0]; next_wd = n_q;
        end
        if (!n_q[LW-1]) begin
          prev_we = 1'b1; prev_wa = n_q[AW-1:0]; prev_wd = p_q;
        end
        if (avail_q != '0) avail_d = avail_q - 1'b1;
        state_we = 1'b1; state_wa = f_q[AW-1:0]; state_wd = btffa_pkg::BLK_USED;
        used_d = used_q + 1'b1;
        pay_d = AW'(f_q[AW-1:0] + HEAD16);
        if (split_w) begin
          size_we = 1'b1; size_wa = f_q[AW-1:0]; size_wd = req_q[SW-1:0];
          foot_we = 1'b1; foot_wa = AW'(f_q + HEAD17 + req_q);
          foot_wd = req_q[SW-1:0];
          state_d = S_A_SP1;
        end else begin
          state_d = S_RESP;
        end
      end
      // remainder block, pushed to the front
      S_A_SP1: begin
        foot_we = 1'b1; foot_wa = AW'(f_q + HEAD17 + {1'b0, olds_q}); foot_wd = left_w;
        size_we = 1'b1; size_wa = nb_w; size_wd = left_w;
        state_we = 1'b1; state_wa = nb_w; state_wd = btffa_pkg::BLK_AVAIL;
        next_we = 1'b1; next_wa = nb_w; next_wd = first_q;
        prev_we = 1'b1; prev_wa = nb_w; prev_wd = NIL;
        state_d = S_A_SP2;
      end
      S_A_SP2: begin
        if (!first_q[LW-1]) begin
          prev_we = 1'b1; prev_wa = first_q[AW-1:0]; prev_wd = {1'b0, nb_w};
        end
        first_d = {1'b0, nb_w};
        avail_d = avail_q + 1'b1;
        state_d = S_RESP;
      end
      // free: check the header
      S_F_CHK: begin
        hdr_ra = b_w;
        b_d = b_w;
        if (fo_q < HEAD16 || {1'b0, b_w} >= hs_q) begin
          status_d = btffa_pkg::ST_BADFREE;
          state_d  = S_RESP;
        end else begin
          state_d = S_F_EV;
        end
      end
      S_F_EV: begin
        if (state_rd_q != btffa_pkg::BLK_USED) begin
          status_d = btffa_pkg::ST_BADFREE;
          state_d  = S_RESP;
        end else begin
          if (used_q != '0) used_d = used_q - 1'b1;
          state_we = 1'b1; state_wa = b_q; state_wd = btffa_pkg::BLK_AVAIL;
          next_we = 1'b1; next_wa = b_q; next_wd = first_q;
          prev_we = 1'b1; prev_wa = b_q; prev_wd = NIL;
          state_d = S_F_P2;
        end
      end
      S_F_P2: begin
        if (!first_q[LW-1]) begin
          prev_we = 1'b1; prev_wa = first_q[AW-1:0]; prev_wd = {1'b0, b_q};
        end
        first_d = {1'b0, b_q};
        avail_d = avail_q + 1'b1;
        lo_d = {1'b0, b_q};
        phase_d = 1'b0;
        state_d = S_M_RD;
      end
      // merge with the block above
      S_M_RD: begin
        hdr_ra = lo_q[AW-1:0];
        state_d = lo_q[LW-1] ? S_M_END : S_M_EV1;
      end
      S_M_EV1: begin
        hdr_ra = up_w[AW-1:0];
        szlo_d = size_rd_q;
        plo_d = prev_rd_q;
        nlo_d = next_rd_q;
        up_d = up_w[AW-1:0];
        if (state_rd_q != btffa_pkg::BLK_AVAIL || up_w >= {1'b0, hs_q}) begin
          state_d = S_M_END;
        end else begin
          state_d = S_M_EV2;
        end
      end
      S_M_EV2: begin
        if (state_rd_q != btffa_pkg::BLK_AVAIL) begin
          state_d = S_M_END;
        end else begin
          szup_d = size_rd_q;
          pup_d = pup_w;
          nup_d = nup_w;
          if (plo_q[LW-1]) begin
            first_d = nlo_q;
          end else begin
            next_we = 1'b1; next_wa = plo_q[AW-1:0]; next_wd = nlo_q;
          end
          if (!nlo_q[LW-1]) begin
            prev_we = 1'b1; prev_wa = nlo_q[AW-1:0]; prev_wd = plo_q;
          end
          if (avail_q != '0) avail_d = avail_q - 1'b1;
          state_d = S_M_RU;
        end
      end
      S_M_RU: begin
        if (pup_q[LW-1]) begin
          first_d = nup_q;
        end else begin
          next_we = 1'b1; next_wa = pup_q[AW-1:0]; next_wd = nup_q;
        end
        if (!nup_q[LW-1]) begin
          prev_we = 1'b1; prev_wa = nup_q[AW-1:0]; prev_wd = pup_q;
        end
        if (avail_q != '0) avail_d = avail_q - 1'b1;
        size_we = 1'b1; size_wa = lo_q[AW-1:0]; size_wd = ns_w;
        foot_we = 1'b1; foot_wa = AW'(lo_q + HEAD17 + {1'b0, ns_w}); foot_wd = ns_w;
        state_d = S_M_P1;
      end
      S_M_P1: begin
        next_we = 1'b1; next_wa = lo_q[AW-1:0]; next_wd = first_q;
        prev_we = 1'b1; prev_wa = lo_q[AW-1:0]; prev_wd = NIL;
        state_d = S_M_P2;
      end
      S_M_P2: begin
        if (!first_q[LW-1]) begin
          prev_we = 1'b1; prev_wa = first_q[AW-1:0]; prev_wd = lo_q;
        end
        first_d = lo_q;
        avail_d = avail_q + 1'b1;
        state_d = S_M_END;
      end
      // after the upper merge, look for the block below; after the lower one, respond
      S_M_END: begin
        foot_ra = bb_f;
        if (phase_q) begin
          state_d = S_RESP;
        end else begin
          phase_d = 1'b1;
          if (b_q < FOOT16) begin
            lo_d = NIL;
            state_d = S_M_RD;
          end else begin
            state_d = S_B_EV;
          end
        end
      end
      S_B_EV: begin
        if ({1'b0, bb_f} < bb_lim) begin
          lo_d = NIL;
        end else begin
          lo_d = {1'b0, AW'(bb_f - HEAD16 - foot_rd_q)};
        end
        state_d = S_M_RD;
      end
      // hand the result to the output register
      S_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b0, used_q, avail_q, pay_q};
          out_user_d  = status_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase

    // heap_size write rebuilds the heap
    if (cfg_we) begin
      hs_d = hs_sat;
      first_d = '0;
      avail_d = CW'(1);
      used_d = '0;
      clr_d = '0;
      state_d = S_CLR;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      hs_q        <= HMAX;
      first_q     <= '0;
      avail_q     <= CW'(1);
      used_q      <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hs_q        <= hs_d;
      first_q     <= first_d;
      avail_q     <= avail_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    req_q <= req_d;   fo_q <= fo_d;     f_q <= f_d;     k_q <= k_d;
    olds_q <= olds_d; p_q <= p_d;       n_q <= n_d;     b_q <= b_d;
    lo_q <= lo_d;     up_q <= up_d;     szlo_q <= szlo_d; szup_q <= szup_d;
    plo_q <= plo_d;   nlo_q <= nlo_d;   pup_q <= pup_d; nup_q <= nup_d;
    status_q <= status_d; pay_q <= pay_d;
    out_data_q <= out_data_d; out_user_q <= out_user_d;
  end

  // Header memories, one read port shared by all fields
  always_ff @(posedge clk_i) begin
    if (size_we)  size_mem[size_wa]   <= size_wd;
    if (state_we) state_mem[state_wa] <= state_wd;
    if (next_we)  next_mem[next_wa]   <= next_wd;
    if (prev_we)  prev_mem[prev_wa]   <= prev_wd;
    size_rd_q  <= size_mem[hdr_ra];
    state_rd_q <= state_mem[hdr_ra];
    next_rd_q  <= next_mem[hdr_ra];
    prev_rd_q  <= prev_mem[hdr_ra];
  end

  // Footer memory
  always_ff @(posedge clk_i) begin
    if (foot_we) foot_mem[foot_wa] <= foot_wd;
    foot_rd_q <= foot_mem[foot_ra];
  end

endmodule

### dv/btffa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// btffa_checker
// Watches the request, response and APB channels of the heap allocator. It
// keeps its own boundary-tag heap, predicts one response per accepted request
// and compares each response transfer field by field with the oldest one.
// ----------------------------------------------------------------------------
module btffa_checker
  import btffa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [16:0] request_size, [32:17] free_offset
  input  logic        s_axis_tuser,   // [0] operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // [15:0] payload_offset, [26:16] avail_count,
                                      // [37:27] used_count
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      payload;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] used;
  } heap_resp_t;

  localparam int unsigned LINK_NIL = STORE_BYTES;

  // Shadow tag store; out-of-range reads give zero, writes are dropped
  int unsigned tag_size  [STORE_BYTES];
  bit [1:0]    tag_state [STORE_BYTES];
  int unsigned tag_next  [STORE_BYTES];
  int unsigned tag_prev  [STORE_BYTES];
  int unsigned tag_foot  [STORE_BYTES];
  int unsigned free_head, free_blocks, busy_blocks, heap_limit;

  heap_resp_t resp_q[$];
  int         fails;

  assign fail_count_o = fails;
  assign pending_o    = resp_q.size();

  function automatic void heap_rebuild(int unsigned v);
    if (v < HEAP_MIN) v = HEAP_MIN;
    if (v > STORE_BYTES) v = STORE_BYTES;
    heap_limit = v;
    for (int i = 0; i < STORE_BYTES; i++) begin
      tag_size[i] = 0; tag_state[i] = 0; tag_next[i] = 0;
      tag_prev[i] = 0; tag_foot[i] = 0;
    end
    tag_size[0]              = v - OVERHEAD;
    tag_state[0]             = BLK_AVAIL;
    tag_foot[v - FOOT_BYTES] = v - OVERHEAD;
    tag_next[0]              = LINK_NIL;
    tag_prev[0]              = LINK_NIL;
    free_head   = 0;
    free_blocks = 1;
    busy_blocks = 0;
  endfunction

  function automatic void free_list_push(int unsigned b);
    tag_next[b] = free_head;
    if (free_head != LINK_NIL) tag_prev[free_head] = b;
    tag_prev[b] = LINK_NIL;
    free_head   = b;
    free_blocks++;
  endfunction

  function automatic void free_list_unlink(int unsigned b);
    int unsigned p, n;
    p = tag_prev[b];
    n = tag_next[b];
    if (p >= LINK_NIL) free_head = n; else tag_next[p] = n;
    if (n < LINK_NIL) tag_prev[n] = p;
    if (free_blocks > 0) free_blocks--;
    tag_next[b] = LINK_NIL;
    tag_prev[b] = LINK_NIL;
  endfunction

  function automatic int unsigned neighbor_below(int unsigned b);
    int unsigned f, s;
    if (b < FOOT_BYTES) return LINK_NIL;
    f = b - FOOT_BYTES;
    s = tag_foot[f];
    if (f < HEAD_BYTES + s) return LINK_NIL;
    return f - HEAD_BYTES - s;
  endfunction

  // Join block lo with the block above it when both are available
  function automatic void coalesce_up(int unsigned lo);
    int unsigned up, ns;
    if (lo >= LINK_NIL || tag_state[lo] != BLK_AVAIL) return;
    up = lo + tag_size[lo] + OVERHEAD;
    if (up >= heap_limit || tag_state[up] != BLK_AVAIL) return;
    free_list_unlink(lo);
    free_list_unlink(up);
    ns = tag_size[lo] + OVERHEAD + tag_size[up];
    tag_size[lo] = ns;
    tag_foot[lo + HEAD_BYTES + ns] = ns;
    free_list_push(lo);
  endfunction

  function automatic heap_resp_t heap_request(op_e op, int unsigned req, int unsigned fo);
    heap_resp_t  r;
    int unsigned f, k, olds, nb, b;
    bit          found;
    r = '0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      f = free_head; k = 0; found = 0;
      while (f < LINK_NIL && k < free_blocks) begin
        if (tag_state[f] == BLK_AVAIL && tag_size[f] >= req) begin
          found = 1;
          break;
        end
        f = tag_next[f];
        k++;
      end
      if (!found) begin
        r.status = ST_NOFIT;
      end else begin
        olds = tag_size[f];
        free_list_unlink(f);
        tag_state[f] = BLK_USED;
        busy_blocks++;
        // split off the tail when it can carry its own tags
        if (olds >= req + OVERHEAD) begin
          nb = f + req + OVERHEAD;
          tag_size[f] = req;
          tag_foot[f + HEAD_BYTES + req]  = req;
          tag_foot[f + HEAD_BYTES + olds] = olds - req - OVERHEAD;
          tag_size[nb]  = olds - req - OVERHEAD;
          tag_state[nb] = BLK_AVAIL;
          free_list_push(nb);
        end
        r.payload = 16'(f + HEAD_BYTES);
      end
    end else begin
      b = fo - HEAD_BYTES;
      if (fo < HEAD_BYTES || b >= heap_limit || tag_state[b] != BLK_USED) begin
        r.status = ST_BADFREE;
      end else begin
        if (busy_blocks > 0) busy_blocks--;
        tag_state[b] = BLK_AVAIL;
        free_list_push(b);
        coalesce_up(b);
        coalesce_up(neighbor_below(b));
      end
    end
    r.avail = CNT_W'(free_blocks);
    r.used  = CNT_W'(busy_blocks);
    return r;
  endfunction

  initial heap_rebuild(STORE_BYTES);

  // Compare responses first, then predict the newly accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    heap_resp_t want, got;
    if (!rst_ni) begin
      heap_rebuild(STORE_BYTES);
      resp_q.delete();
      fails <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[26:16], m_axis_tdata[37:27]};
        if (resp_q.size() == 0) begin
          if (fails < 10) $display("%0t: response with nothing outstanding: %h", $time, got);
          fails <= fails + 1;
        end else begin
          want = resp_q.pop_front();
          if (got !== want) begin
            if (fails < 10)
              $display("%0t: mismatch st %0d/%0d pay %0d/%0d avail %0d/%0d used %0d/%0d",
                       $time, want.status, got.status, want.payload, got.payload,
                       want.avail, got.avail, want.used, got.used);
            fails <= fails + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        resp_q.push_back(heap_request(op_e'(s_axis_tuser), 32'(s_axis_tdata[16:0]),
                                      32'(s_axis_tdata[32:17])));
      if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_SIZE)
        heap_rebuild(pwdata & 32'h1FFFF);
    end
  end

endmodule

### dv/boundary_tag_first_fit_allocator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator_top_tb
// Drives allocate and free traffic over several heap sizes with random gaps
// and receiver stalls; a checker module predicts and compares every response.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator_top_tb;
  import btffa_pkg::*;

  localparam int unsigned STALL_LIMIT = 200000;

  logic        clk, rst_n;
  logic        s_tvalid, s_tready, s_tuser;
  logic [39:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  int          fail_count, pending;
  int unsigned idle_edges;
  int unsigned cur_heap;
  logic        calm;
  logic [15:0] live_offsets[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  boundary_tag_first_fit_allocator_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  btffa_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stalls; also harvest granted offsets for later frees
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
      if (m_tvalid && m_tready && m_tuser == ST_OK && m_tdata[15:0] != 16'd0)
        live_offsets.push_back(m_tdata[15:0]);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_edges <= 0;
    else
      idle_edges <= idle_edges + 1;
    if (idle_edges >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(op_e op, int unsigned req, int unsigned fo);
    if (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 32) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, fo[15:0], req[16:0]};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait for every outstanding response
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_heap(logic [2:0] addr, int unsigned v);
    apb_write(addr, v);
    if (addr[2] == REG_HEAP_SIZE) begin
      live_offsets.delete();
      cur_heap = (v & 32'h1FFFF) < HEAP_MIN ? HEAP_MIN :
                 (v & 32'h1FFFF) > STORE_BYTES ? STORE_BYTES : (v & 32'h1FFFF);
    end
  endtask

  // Mostly well-formed alloc/free mixes, some noise; a calm window in the middle
  task automatic random_traffic(int n);
    int unsigned pick, req, idx;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 3 + n / 5);
      pick = $urandom_range(99);
      if (pick < 50) begin
        req = ($urandom_range(9) == 0) ? $urandom_range(cur_heap) :
              $urandom_range(cur_heap / 16 + 8);
        send_item(OP_ALLOC, req, $urandom);
      end else if (pick < 85 && live_offsets.size() != 0) begin
        idx = $urandom_range(live_offsets.size() - 1);
        send_item(OP_FREE, $urandom, 32'(live_offsets[idx]));
        if ($urandom_range(9) != 0) live_offsets.delete(idx);
      end else begin
        send_item(op_e'($urandom_range(1)), $urandom_range(17'h1FFFF),
                  $urandom_range(16'hFFFF));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    calm     = 1'b0;
    idle_edges = 0;
    cur_heap = STORE_BYTES;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, bad frees, exact and unsplittable fits, merges
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_ALLOC, 1, 16'hFFFF);
    send_item(OP_ALLOC, 65536, 0);
    send_item(OP_ALLOC, 17'h1FFFF, 0);
    send_item(OP_FREE, 0, 0);
    send_item(OP_FREE, 0, 31);
    send_item(OP_FREE, 0, 16'hFFFF);
    send_item(OP_FREE, 0, 72);
    send_item(OP_FREE, 0, 32);
    send_item(OP_FREE, 0, 32);            // double free
    send_item(OP_ALLOC, STORE_BYTES - OVERHEAD, 0);
    send_item(OP_ALLOC, 0, 0);            // heap exhausted
    send_item(OP_FREE, 0, 32);
    send_item(OP_ALLOC, STORE_BYTES - OVERHEAD - 36, 0);  // tail too small to split
    send_item(OP_FREE, 0, 32);
    send_item(OP_ALLOC, 8, 0);
    send_item(OP_ALLOC, 8, 0);
    send_item(OP_ALLOC, 8, 0);
    send_item(OP_FREE, 0, 80);            // neighbors used
    send_item(OP_FREE, 0, 32);            // merge with block above
    send_item(OP_FREE, 0, 128);           // merge above and below
    drain();
    live_offsets.delete();

    random_traffic(180);
    drain();
    set_heap(3'd0, 0);                    // saturates to minimum
    random_traffic(20);
    drain();
    set_heap(3'd4, 1000);                 // unknown register
    random_traffic(20);
    drain();
    set_heap(3'd0, 1000);
    random_traffic(80);
    drain();
    set_heap(3'd0, 17'h1FFFF);            // saturates to maximum
    random_traffic(60);
    drain();
    set_heap(3'd0, 48);
    random_traffic(20);
    drain();

    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
hdl/btffa_pkg.sv
hdl/boundary_tag_first_fit_allocator_top.sv
dv/btffa_checker.sv
dv/boundary_tag_first_fit_allocator_top_tb.sv
